// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on i_clk, idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ccd_pkg.sv =====
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int NF_W        = SAMPLE_BITS + FRAC_BITS;
    localparam int TIME_W      = 32;

    localparam int CFG_AMP_W    = 12;
    localparam int CFG_MARGIN_W = 12;
    localparam int CFG_TIME_W   = 32;
    localparam int ALPHA_W      = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;

    localparam int PROD_W  = ALPHA_W + NF_W;
    localparam int MARGQ_W = CFG_MARGIN_W + FRAC_BITS;
    localparam int SUM_W   = ((NF_W > MARGQ_W) ? NF_W : MARGQ_W) + 1;
    localparam int AMPC_W  = (SAMPLE_BITS > CFG_AMP_W) ? SAMPLE_BITS : CFG_AMP_W;

    localparam logic [NF_W-1:0]       NF_RESET   = NF_W'(150 << FRAC_BITS);
    localparam logic [CFG_AMP_W-1:0]  MIN_AMP_RESET  = CFG_AMP_W'(100);
    localparam logic [CFG_MARGIN_W-1:0] MARGIN_RESET = CFG_MARGIN_W'(200);
    localparam logic [CFG_TIME_W-1:0] DEBOUNCE_RESET = CFG_TIME_W'(150000);
    localparam logic [CFG_TIME_W-1:0] WINDOW_RESET   = CFG_TIME_W'(400000);
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = ALPHA_W'(3277);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_AMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_SPIN = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_CW   = 2'd1,
        CMD_CCW  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   burst_end;
        logic [TIME_W-1:0]      time_us;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] amplitude;
        logic                   clap;
        logic [1:0]             spin_command;
        logic [1:0]             detector_mode;
        logic [SAMPLE_BITS-1:0] floor_level;
    } t_out;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] amp;
        logic [TIME_W-1:0]      now;
    } t_burst;

    typedef struct packed {
        logic           we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

// ===== src/ccd_front.sv =====
`timescale 1ns / 1ps

module ccd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ccd_pkg::t_in  i_in,
    output logic          o_push,
    output ccd_pkg::t_burst o_burst,
    input  logic          i_full
);

    logic [ccd_pkg::SAMPLE_BITS-1:0] r_max, n_max;
    logic [ccd_pkg::SAMPLE_BITS-1:0] r_min, n_min;
    logic accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_max = (i_in.sample > r_max) ? i_in.sample : r_max;
        n_min = (i_in.sample < r_min) ? i_in.sample : r_min;
        o_burst.amp = (n_max >= n_min) ? (n_max - n_min) : '0;
        o_burst.now = i_in.time_us;
    end

    assign o_push = accept && i_in.burst_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_min <= '1;
        end else if (accept) begin
            if (i_in.burst_end) begin
                r_max <= '0;
                r_min <= '1;
            end else begin
                r_max <= n_max;
                r_min <= n_min;
            end
        end
    end

endmodule

// ===== src/ccd_queue.sv =====
`timescale 1ns / 1ps

module ccd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccd_pkg::t_burst i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ccd_pkg::t_burst o_data
);

    ccd_pkg::t_burst r_mem [2];
    logic r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== src/ccd_back.sv =====
`timescale 1ns / 1ps

module ccd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ccd_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  ccd_pkg::t_burst i_q_data,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ccd_pkg::t_out   o_out
);

    localparam logic [ccd_pkg::PROD_W:0] ROUND_UP =
        (ccd_pkg::PROD_W + 1)'((1 << ccd_pkg::ALPHA_W) - 1);

    logic [ccd_pkg::CFG_AMP_W-1:0]    r_min_amp;
    logic [ccd_pkg::CFG_MARGIN_W-1:0] r_margin;
    logic [ccd_pkg::CFG_TIME_W-1:0]   r_debounce;
    logic [ccd_pkg::CFG_TIME_W-1:0]   r_window;
    logic [ccd_pkg::ALPHA_W-1:0]      r_alpha;

    logic [ccd_pkg::NF_W-1:0]   r_nf, n_nf;
    logic [ccd_pkg::TIME_W-1:0] r_last, n_last;
    logic [ccd_pkg::TIME_W-1:0] r_wait, n_wait;
    ccd_pkg::t_mode r_mode, n_mode;
    ccd_pkg::t_cmd  r_cmd, n_cmd;

    logic r_busy;
    logic r_neg;
    logic [ccd_pkg::PROD_W-1:0]      r_prod;
    logic [ccd_pkg::SAMPLE_BITS-1:0] r_amp;
    logic [ccd_pkg::TIME_W-1:0]      r_now;

    logic [ccd_pkg::NF_W-1:0] ampq_in, diff;
    logic neg;
    logic fin;

    logic [ccd_pkg::PROD_W:0]   rounded;
    logic [ccd_pkg::NF_W-1:0]   step;
    logic [ccd_pkg::NF_W-1:0]   ampq;
    logic [ccd_pkg::SUM_W-1:0]  thresh;
    logic [ccd_pkg::TIME_W-1:0] dt_clap, dt_wait;
    logic loud, clap;

    ccd_pkg::t_out r_out;

    assign o_pop = !r_busy && i_q_valid;
    assign fin   = r_busy && (!o_out_valid || !i_out_stall);

    // multiply stage
    always_comb begin
        ampq_in = {i_q_data.amp, {ccd_pkg::FRAC_BITS{1'b0}}};
        neg     = ampq_in < r_nf;
        diff    = neg ? (r_nf - ampq_in) : (ampq_in - r_nf);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod <= ccd_pkg::PROD_W'(r_alpha) * ccd_pkg::PROD_W'(diff);
            r_neg  <= neg;
            r_amp  <= i_q_data.amp;
            r_now  <= i_q_data.now;
        end
    end

    // floor update, clap decision
    always_comb begin
        rounded = {1'b0, r_prod} + (r_neg ? ROUND_UP : '0);
        step    = rounded[ccd_pkg::ALPHA_W +: ccd_pkg::NF_W];
        n_nf    = r_neg ? (r_nf - step) : (r_nf + step);
        ampq    = {r_amp, {ccd_pkg::FRAC_BITS{1'b0}}};
        thresh  = ccd_pkg::SUM_W'(n_nf)
                + ccd_pkg::SUM_W'({r_margin, {ccd_pkg::FRAC_BITS{1'b0}}});
        dt_clap = r_now - r_last;
        dt_wait = r_now - r_wait;
        loud    = (ccd_pkg::AMPC_W'(r_amp) > ccd_pkg::AMPC_W'(r_min_amp))
               && (ccd_pkg::SUM_W'(ampq) > thresh);
        clap    = loud && (dt_clap > r_debounce);
        n_last  = clap ? r_now : r_last;
    end

    always_comb begin
        n_mode = r_mode;
        n_cmd  = r_cmd;
        n_wait = r_wait;
        unique case (r_mode)
            ccd_pkg::MODE_WAIT: begin
                if (clap) begin
                    n_cmd  = ccd_pkg::CMD_CCW;
                    n_mode = ccd_pkg::MODE_SPIN;
                end else if (dt_wait > r_window) begin
                    n_cmd  = ccd_pkg::CMD_CW;
                    n_mode = ccd_pkg::MODE_SPIN;
                end
            end
            ccd_pkg::MODE_SPIN: begin
                if (clap) begin
                    n_cmd  = ccd_pkg::CMD_STOP;
                    n_mode = ccd_pkg::MODE_IDLE;
                end
            end
            default: begin
                n_mode = ccd_pkg::MODE_IDLE;
                if (clap) begin
                    if (r_cmd == ccd_pkg::CMD_STOP) begin
                        n_mode = ccd_pkg::MODE_WAIT;
                        n_wait = r_now;
                    end else begin
                        n_cmd = ccd_pkg::CMD_STOP;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_amp  <= ccd_pkg::MIN_AMP_RESET;
            r_margin   <= ccd_pkg::MARGIN_RESET;
            r_debounce <= ccd_pkg::DEBOUNCE_RESET;
            r_window   <= ccd_pkg::WINDOW_RESET;
            r_alpha    <= ccd_pkg::ALPHA_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                ccd_pkg::REG_MIN_AMP:  r_min_amp  <= i_cfg.data[ccd_pkg::CFG_AMP_W-1:0];
                ccd_pkg::REG_MARGIN:   r_margin   <= i_cfg.data[ccd_pkg::CFG_MARGIN_W-1:0];
                ccd_pkg::REG_DEBOUNCE: r_debounce <= i_cfg.data[ccd_pkg::CFG_TIME_W-1:0];
                ccd_pkg::REG_WINDOW:   r_window   <= i_cfg.data[ccd_pkg::CFG_TIME_W-1:0];
                ccd_pkg::REG_ALPHA:    r_alpha    <= i_cfg.data[ccd_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_nf        <= ccd_pkg::NF_RESET;
            r_last      <= '0;
            r_wait      <= '0;
            r_mode      <= ccd_pkg::MODE_IDLE;
            r_cmd       <= ccd_pkg::CMD_STOP;
            o_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
            end
            if (fin) begin
                r_nf        <= n_nf;
                r_last      <= n_last;
                r_wait      <= n_wait;
                r_mode      <= n_mode;
                r_cmd       <= n_cmd;
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out.amplitude     <= r_amp;
            r_out.clap          <= clap;
            r_out.spin_command  <= n_cmd;
            r_out.detector_mode <= n_mode;
            r_out.floor_level   <= n_nf[ccd_pkg::NF_W-1 -: ccd_pkg::SAMPLE_BITS];
        end
    end

    assign o_out = r_out;

endmodule

// ===== src/clap_command_detector.sv =====
`timescale 1ns / 1ps

// Clap command detector. Takes one microphone sample per cycle; the front end
// tracks the burst max/min and, on the burst-end beat, queues the amplitude and
// timestamp in a two-entry queue. The back end handles one burst at a time (first the
// registered alpha * difference multiply, then the floor update, clap test and mode
// step, which waits while the output is stalled) and takes no new burst until it has
// finished the last one, while ordinary samples go at one per cycle
// as long as the queue has room. Results leave through an output register; the
// input stalls only when the queue holds two bursts. Configuration writes take
// effect at once and are meant for an idle block.

`include "assert_macros.svh"

module clap_command_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ccd_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ccd_pkg::t_out                 o_out
);

    ccd_pkg::t_burst push_data, pop_data;
    ccd_pkg::t_cfg   cfg;
    logic push, pop, q_full, q_valid;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    ccd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_in    (i_in),
        .o_push  (push),
        .o_burst (push_data),
        .i_full  (q_full)
    );

    ccd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    ccd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    `CCD_ASSERT_SAME(a_spin_moves, o_out_valid && o_out.detector_mode == ccd_pkg::MODE_SPIN,
        o_out.spin_command != ccd_pkg::CMD_STOP)
    `CCD_ASSERT_SAME(a_wait_still, o_out_valid && o_out.detector_mode == ccd_pkg::MODE_WAIT,
        o_out.spin_command == ccd_pkg::CMD_STOP)
    `CCD_ASSERT_SAME(a_clap_loud, o_out_valid && o_out.clap, o_out.amplitude != '0)
    `CCD_ASSERT_NEXT(a_queue_pop, q_valid && !pop, pop || q_valid)

endmodule

// ===== dv/ccd_checker.sv =====
`timescale 1ns / 1ps

module ccd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  ccd_pkg::t_in                   i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  ccd_pkg::t_out                  i_out,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic [ccd_pkg::CFG_AMP_W-1:0]    gate_amp;
    logic [ccd_pkg::CFG_MARGIN_W-1:0] margin;
    logic [ccd_pkg::CFG_TIME_W-1:0]   debounce_win;
    logic [ccd_pkg::CFG_TIME_W-1:0]   pair_win;
    logic [ccd_pkg::ALPHA_W-1:0]      alpha;

    logic [ccd_pkg::SAMPLE_BITS-1:0]  peak_hi;
    logic [ccd_pkg::SAMPLE_BITS-1:0]  peak_lo;
    logic [ccd_pkg::NF_W-1:0]         floor_q;
    logic [ccd_pkg::TIME_W-1:0]       last_clap_us;
    logic [ccd_pkg::TIME_W-1:0]       wait_t0_us;
    ccd_pkg::t_mode                   mode_q;
    ccd_pkg::t_cmd                    cmd_q;

    ccd_pkg::t_out bursts_due[$];
    int            fails = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        fails++;
    endtask

    task automatic reset_model();
        gate_amp     = ccd_pkg::MIN_AMP_RESET;
        margin       = ccd_pkg::MARGIN_RESET;
        debounce_win = ccd_pkg::DEBOUNCE_RESET;
        pair_win     = ccd_pkg::WINDOW_RESET;
        alpha        = ccd_pkg::ALPHA_RESET;
        peak_hi      = '0;
        peak_lo      = '1;
        floor_q      = ccd_pkg::NF_RESET;
        last_clap_us = '0;
        wait_t0_us   = '0;
        mode_q       = ccd_pkg::MODE_IDLE;
        cmd_q        = ccd_pkg::CMD_STOP;
        bursts_due.delete();
    endtask

    task automatic write_reg(input logic [ccd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccd_pkg::CFG_DATA_W-1:0] data);
        unique case (idx)
            ccd_pkg::REG_MIN_AMP:  gate_amp = data[ccd_pkg::CFG_AMP_W-1:0];
            ccd_pkg::REG_MARGIN:   margin = data[ccd_pkg::CFG_MARGIN_W-1:0];
            ccd_pkg::REG_DEBOUNCE: debounce_win = data[ccd_pkg::CFG_TIME_W-1:0];
            ccd_pkg::REG_WINDOW:   pair_win = data[ccd_pkg::CFG_TIME_W-1:0];
            ccd_pkg::REG_ALPHA:    alpha = data[ccd_pkg::ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    // fold one sample into the burst; on burst end, update floor and mode and queue the result
    task automatic fold_sample(input ccd_pkg::t_in beat);
        logic [ccd_pkg::SAMPLE_BITS-1:0] amp;
        logic [ccd_pkg::NF_W-1:0]        amp_q;
        logic [ccd_pkg::PROD_W-1:0]      step;
        logic [ccd_pkg::SUM_W-1:0]       thresh;
        logic                            clap;
        ccd_pkg::t_out                   res;
        if (beat.sample > peak_hi) peak_hi = beat.sample;
        if (beat.sample < peak_lo) peak_lo = beat.sample;
        if (beat.burst_end) begin
            amp = (peak_hi >= peak_lo) ? peak_hi - peak_lo : '0;
            peak_hi = '0;
            peak_lo = '1;
            amp_q = {amp, {ccd_pkg::FRAC_BITS{1'b0}}};
            if (amp_q >= floor_q) begin
                step = ccd_pkg::PROD_W'(alpha) * ccd_pkg::PROD_W'(amp_q - floor_q);
                floor_q = floor_q + step[ccd_pkg::PROD_W-1:16];
            end else begin
                step = ccd_pkg::PROD_W'(alpha) * ccd_pkg::PROD_W'(floor_q - amp_q)
                     + ccd_pkg::PROD_W'(16'hFFFF);
                floor_q = floor_q - step[ccd_pkg::PROD_W-1:16];
            end
            thresh = ccd_pkg::SUM_W'(floor_q)
                   + ccd_pkg::SUM_W'({margin, {ccd_pkg::FRAC_BITS{1'b0}}});
            clap = 1'b0;
            if (amp > gate_amp && ccd_pkg::SUM_W'(amp_q) > thresh) begin
                if (ccd_pkg::TIME_W'(beat.time_us - last_clap_us) > debounce_win) begin
                    clap = 1'b1;
                    last_clap_us = beat.time_us;
                end
            end
            unique case (mode_q)
                ccd_pkg::MODE_WAIT: begin
                    if (clap) begin
                        cmd_q = ccd_pkg::CMD_CCW;
                        mode_q = ccd_pkg::MODE_SPIN;
                    end else if (ccd_pkg::TIME_W'(beat.time_us - wait_t0_us) > pair_win) begin
                        cmd_q = ccd_pkg::CMD_CW;
                        mode_q = ccd_pkg::MODE_SPIN;
                    end
                end
                ccd_pkg::MODE_SPIN: begin
                    if (clap) begin
                        cmd_q = ccd_pkg::CMD_STOP;
                        mode_q = ccd_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    mode_q = ccd_pkg::MODE_IDLE;
                    if (clap) begin
                        if (cmd_q == ccd_pkg::CMD_STOP) begin
                            mode_q = ccd_pkg::MODE_WAIT;
                            wait_t0_us = beat.time_us;
                        end else begin
                            cmd_q = ccd_pkg::CMD_STOP;
                        end
                    end
                end
            endcase
            res.amplitude     = amp;
            res.clap          = clap;
            res.spin_command  = cmd_q;
            res.detector_mode = mode_q;
            res.floor_level   = floor_q[ccd_pkg::NF_W-1:ccd_pkg::FRAC_BITS];
            bursts_due.push_back(res);
        end
    endtask

    task automatic check_burst(input ccd_pkg::t_out got);
        ccd_pkg::t_out want;
        if (bursts_due.size() == 0) begin
            report_mismatch("unexpected burst result, amplitude", got.amplitude, -1);
        end else begin
            want = bursts_due.pop_front();
            if (got.amplitude !== want.amplitude)
                report_mismatch("amplitude", got.amplitude, want.amplitude);
            if (got.clap !== want.clap)
                report_mismatch("clap", got.clap, want.clap);
            if (got.spin_command !== want.spin_command)
                report_mismatch("spin_command", got.spin_command, want.spin_command);
            if (got.detector_mode !== want.detector_mode)
                report_mismatch("detector_mode", got.detector_mode, want.detector_mode);
            if (got.floor_level !== want.floor_level)
                report_mismatch("floor_level", got.floor_level, want.floor_level);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !i_in_stall) fold_sample(i_in);
            if (i_out_valid && !i_out_stall) check_burst(i_out);
        end
        o_fail_count <= fails;
        o_pending    <= bursts_due.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int PERIOD         = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEM_TARGET    = 1250;
    localparam int DIRECTED_ITEMS = 25;
    localparam int PHASES         = 5;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        SHAPE_QUIET,
        SHAPE_CLAP,
        SHAPE_WILD
    } t_shape;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ccd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ccd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    ccd_pkg::t_in                   in_beat;
    logic                           out_valid;
    logic                           out_stall;
    ccd_pkg::t_out                  out_beat;
    int                             fail_count;
    int                             pending;

    int                             items_sent  = 0;
    int                             cycle_count = 0;
    bit                             calm        = 1'b0;
    logic [ccd_pkg::TIME_W-1:0]     now_us;
    logic [ccd_pkg::CFG_TIME_W-1:0] cur_debounce = ccd_pkg::DEBOUNCE_RESET;
    logic [ccd_pkg::CFG_TIME_W-1:0] cur_window   = ccd_pkg::WINDOW_RESET;

    always #(PERIOD / 2) clk = ~clk;

    clap_command_detector u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    ccd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic push_beat(input logic [ccd_pkg::SAMPLE_BITS-1:0] s, input logic last,
                             input logic [ccd_pkg::TIME_W-1:0] t);
        ccd_pkg::t_in b;
        b.sample    = s;
        b.burst_end = last;
        b.time_us   = t;
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_pair(input logic [ccd_pkg::SAMPLE_BITS-1:0] lo,
                             input logic [ccd_pkg::SAMPLE_BITS-1:0] hi,
                             input logic [ccd_pkg::TIME_W-1:0] t_end);
        push_beat(lo, 1'b0, $urandom);
        push_beat(hi, 1'b1, t_end);
    endtask

    function automatic logic [ccd_pkg::TIME_W-1:0] next_gap_us();
        unique case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 20000);
            1, 2:    return cur_debounce + $urandom_range(1, 60000);
            3:       return cur_debounce - $urandom_range(0, 20000);
            4, 5:    return $urandom_range(0, cur_window);
            6:       return cur_window + $urandom_range(1, 60000);
            7:       return cur_window - $urandom_range(0, 2);
            8:       return $urandom;
            default: return '0;
        endcase
    endfunction

    task automatic send_burst(input t_shape shape);
        int                              len;
        int                              spike;
        int                              base;
        logic [ccd_pkg::SAMPLE_BITS-1:0] s;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        if (shape == SHAPE_CLAP && len < 2) len = 2;
        spike = $urandom_range(0, len - 1);
        base  = $urandom_range(1000, 3000);
        if (shape == SHAPE_WILD) now_us = $urandom;
        else now_us = now_us + next_gap_us();
        for (int i = 0; i < len; i++) begin
            unique case (shape)
                SHAPE_QUIET: s = ccd_pkg::SAMPLE_BITS'(base - 20 + $urandom_range(0, 40));
                SHAPE_CLAP:  s = (i == spike) ? ccd_pkg::SAMPLE_BITS'($urandom_range(1500, 4095))
                                              : ccd_pkg::SAMPLE_BITS'($urandom_range(0, 900));
                default:     s = ccd_pkg::SAMPLE_BITS'($urandom);
            endcase
            push_beat(s, i == len - 1, (i == len - 1) ? now_us : ccd_pkg::TIME_W'($urandom));
        end
    endtask

    // hold the sender until every pending burst result is back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [ccd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ccd_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [ccd_pkg::CFG_AMP_W-1:0] gate,
                             input logic [ccd_pkg::CFG_MARGIN_W-1:0] marg,
                             input logic [ccd_pkg::CFG_TIME_W-1:0] deb,
                             input logic [ccd_pkg::CFG_TIME_W-1:0] win,
                             input logic [ccd_pkg::ALPHA_W-1:0] alph);
        settle();
        set_reg(ccd_pkg::REG_MIN_AMP, {20'($urandom), gate});
        set_reg(ccd_pkg::REG_MARGIN, {20'($urandom), marg});
        set_reg(ccd_pkg::REG_DEBOUNCE, deb);
        set_reg(ccd_pkg::REG_WINDOW, win);
        set_reg(ccd_pkg::REG_ALPHA, {16'($urandom), alph});
        // unused indexes must be ignored
        for (int k = int'(ccd_pkg::REG_ALPHA) + 1; k < (1 << ccd_pkg::CFG_IDX_W); k++)
            set_reg(ccd_pkg::CFG_IDX_W'(k), $urandom);
        cfg_we <= 1'b0;
        cur_debounce = deb;
        cur_window   = win;
    endtask

    initial begin
        int pick;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= ccd_pkg::REG_MIN_AMP;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_pair(12'h000, 12'hFFF, 32'd0);
        send_pair(12'h000, 12'hFFF, 32'd200000);
        send_pair(12'h000, 12'hFFF, 32'd300000);
        send_pair(12'h000, 12'hFFF, 32'd500000);
        send_pair(12'd2000, 12'd2010, 32'd600000);
        send_pair(12'h000, 12'hFFF, 32'd800000);
        send_pair(12'h000, 12'hFFF, 32'd1000000);
        send_pair(12'd2000, 12'd2010, 32'd1400000);
        send_pair(12'd2000, 12'd2010, 32'd1400001);
        send_pair(12'h000, 12'hFFF, 32'd1600000);
        send_pair(12'h000, 12'hFFF, 32'hFFFF_0000);
        send_pair(12'h000, 12'hFFF, 32'hFFFF_0000 + 32'd400001);
        push_beat(12'hFFF, 1'b1, 32'hFFFF_FFFF);
        now_us = 32'hFFFF_FFFF;

        for (int phase = 0; phase < PHASES; phase++) begin
            unique case (phase)
                0: configure(12'($urandom_range(0, 400)), 12'($urandom_range(0, 600)),
                             $urandom_range(20000, 200000), $urandom_range(200000, 600000),
                             16'($urandom_range(0, 20000)));
                1: configure(12'd0, 12'd0, 32'd0, 32'd0, 16'hFFFF);
                2: configure(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
                3: configure(12'd2000, 12'd100, 32'd1, 32'hFFFF_FFFF, 16'd1);
                default: begin
                    calm = 1'b1;
                    configure(ccd_pkg::MIN_AMP_RESET, ccd_pkg::MARGIN_RESET,
                              ccd_pkg::DEBOUNCE_RESET, ccd_pkg::WINDOW_RESET,
                              ccd_pkg::ALPHA_RESET);
                end
            endcase
            while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEM_TARGET / PHASES) begin
                pick = $urandom_range(0, 9);
                send_burst(pick < 5 ? SHAPE_QUIET : (pick < 8 ? SHAPE_CLAP : SHAPE_WILD));
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
